### design/urd_pkg.sv
// Shared constants, types and the digit character table for the radix digit converter.
// No dependencies.
package urd_pkg;

    localparam int VALUE_BITS   = 32;
    localparam int MAX_DIGITS   = 32;
    localparam int RADIX_W      = 5;
    localparam int DIGIT_W      = 4;
    localparam int CHAR_W       = 7;
    localparam int DIV_BPC      = 8;
    localparam int DIV_STEPS    = (VALUE_BITS + DIV_BPC - 1) / DIV_BPC;
    localparam int DIV_PAD_W    = DIV_STEPS * DIV_BPC;
    localparam int STEP_CNT_W   = $clog2(DIV_STEPS + 1);
    localparam int CNT_W        = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W        = $clog2(MAX_DIGITS);
    localparam int PADDR_W      = 3;
    localparam int PDATA_W      = 32;
    localparam int REG_IDX_W    = PADDR_W - 2;

    localparam logic [RADIX_W-1:0]   RADIX_RESET = RADIX_W'(10);
    localparam logic [RADIX_W-1:0]   RADIX_MIN   = RADIX_W'(2);
    localparam logic [RADIX_W-1:0]   RADIX_MAX   = RADIX_W'(16);
    localparam logic [REG_IDX_W-1:0] REG_RADIX   = REG_IDX_W'(0);

    localparam logic [CHAR_W-1:0] DIGIT_CHARS [16] = '{
        7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
        7'h38, 7'h39, 7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46
    };

    typedef struct packed {
        logic                  start;
        logic [VALUE_BITS-1:0] dividend;
        logic [RADIX_W-1:0]    divisor;
    } t_div_req;

    typedef struct packed {
        logic                  done;
        logic [VALUE_BITS-1:0] quotient;
        logic [DIGIT_W-1:0]    remainder;
    } t_div_rsp;

    function automatic logic [CHAR_W-1:0] digit_ascii(input logic [DIGIT_W-1:0] d);
        return DIGIT_CHARS[d];
    endfunction

endpackage

### design/urd_divider.sv
// Iterative divider of a value by a small radix, DIV_BPC quotient bits per cycle.
// Depends on urd_pkg.
module urd_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  urd_pkg::t_div_req i_req,
    output urd_pkg::t_div_rsp o_rsp
);
    import urd_pkg::*;

    logic                  r_busy;
    logic                  r_done;
    logic [STEP_CNT_W-1:0] r_cnt;
    logic [DIV_PAD_W-1:0]  r_work;
    logic [DIGIT_W-1:0]    r_rem;
    logic [RADIX_W-1:0]    r_div;

    logic [DIV_PAD_W-1:0]  n_work;
    logic [DIGIT_W-1:0]    n_rem;

    always_comb begin
        logic [DIGIT_W:0]     t;
        logic [DIV_PAD_W-1:0] w;
        logic [DIGIT_W-1:0]   rm;
        w  = r_work;
        rm = r_rem;
        for (int j = 0; j < DIV_BPC; j++) begin
            t = {rm, w[DIV_PAD_W-1]};
            w = {w[DIV_PAD_W-2:0], 1'b0};
            if (t >= r_div) begin
                t    = t - r_div;
                w[0] = 1'b1;
            end
            rm = t[DIGIT_W-1:0];
        end
        n_work = w;
        n_rem  = rm;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_work <= DIV_PAD_W'(i_req.dividend);
                r_rem  <= '0;
                r_div  <= i_req.divisor;
            end else if (r_busy) begin
                r_work <= n_work;
                r_rem  <= n_rem;
                if (r_cnt == STEP_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_work[VALUE_BITS-1:0];
    assign o_rsp.remainder = r_rem;

`ifndef NO_ASSERTIONS
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider done without a division in progress");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt < STEP_CNT_W'(DIV_STEPS))
        else $error("divider step count out of range");
    a_not_both: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_done && r_busy))
        else $error("divider busy and done together");
`endif

endmodule

### design/unsigned_to_radix_digits_core.sv
// Top level of the radix digit converter: sequencer, digit store, radix register.
// Depends on urd_pkg and urd_divider.
//
//   channel  signals                         direction
//   input    i_valid/o_ready, i_value        in
//   output   o_valid/i_ready, o_digit_char,  out
//            o_last
//   config   APB: psel penable pwrite paddr  in/out
//            pwdata prdata pready
//
// For each digit urd_divider runs DIV_STEPS steps and hands its quotient back for the next digit,
// and each digit is then read from the store and held for transfer.
// o_ready is low from acceptance until the last digit is transferred.
// Reset is synchronous, active low; radix resets to 10. The digit store needs no clearing.
// A stalled output simply holds the current digit.
module unsigned_to_radix_digits_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [urd_pkg::VALUE_BITS-1:0] i_value,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [urd_pkg::CHAR_W-1:0]     o_digit_char,
    output logic                           o_last,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [urd_pkg::PADDR_W-1:0]    paddr,
    input  logic [urd_pkg::PDATA_W-1:0]    pwdata,
    output logic [urd_pkg::PDATA_W-1:0]    prdata,
    output logic                           pready
);
    import urd_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_RD,
        S_OUT
    } t_state;

    t_state               r_state;
    logic [RADIX_W-1:0]   r_radix;
    logic [CNT_W-1:0]     r_n;
    logic [IDX_W-1:0]     r_rd;
    logic                 r_last;
    logic [DIGIT_W-1:0]   r_rd_data;
    logic [DIGIT_W-1:0]   r_store [MAX_DIGITS];

    t_div_req             div_req;
    t_div_rsp             div_rsp;
    logic                 more;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;
    logic [RADIX_W-1:0]   wr_radix;

    assign reg_idx  = paddr[PADDR_W-1:2];
    assign wr_radix = pwdata[RADIX_W-1:0];
    assign pready   = 1'b1;
    assign prdata   = (reg_idx == REG_RADIX) ? PDATA_W'(r_radix) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_RESET;
        end else if (psel && penable && pwrite && pready && reg_idx == REG_RADIX
                     && wr_radix >= RADIX_MIN && wr_radix <= RADIX_MAX) begin
            r_radix <= wr_radix;
        end
    end

    assign more  = (div_rsp.quotient != '0) && ((r_n + 1'b1) < CNT_W'(MAX_DIGITS));
    assign wr_en = (r_state == S_DIV) && div_rsp.done;

    always_comb begin
        div_req.start    = ((r_state == S_IDLE) && i_valid) || (wr_en && more);
        div_req.dividend = (r_state == S_IDLE) ? i_value : div_rsp.quotient;
        div_req.divisor  = r_radix;
    end

    urd_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[r_n[IDX_W-1:0]] <= div_rsp.remainder;
        end
        r_rd_data <= r_store[r_rd];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_n     <= '0;
            r_rd    <= '0;
            r_last  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_n     <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        r_n <= r_n + 1'b1;
                        if (!more) begin
                            r_rd    <= r_n[IDX_W-1:0];
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    r_last  <= (r_rd == '0);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_ready) begin
                        if (r_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_rd    <= r_rd - 1'b1;
                            r_state <= S_RD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready      = (r_state == S_IDLE);
    assign o_valid      = (r_state == S_OUT);
    assign o_last       = r_last;
    assign o_digit_char = digit_ascii(r_rd_data);

`ifndef NO_ASSERTIONS
    a_radix_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_radix >= RADIX_MIN && r_radix <= RADIX_MAX)
        else $error("radix register outside its legal range");
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (!o_ready && !o_valid))
        else $error("converter not busy after accepting a value");
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide phase");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= CNT_W'(MAX_DIGITS))
        else $error("digit count beyond the store depth");
    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_last) |=> o_ready)
        else $error("converter not idle after the final digit");
`endif

endmodule

### bench/unsigned_to_radix_digits_core_tb.sv
// Testbench for unsigned_to_radix_digits_core: predicts the digit stream of each value and
// checks every transferred digit, under random stalls on both channels and APB radix writes.
// Depends on urd_pkg and the RTL of the converter.
module unsigned_to_radix_digits_core_tb;
    import urd_pkg::*;

    localparam int HALF_PERIOD  = 4;
    localparam int RESET_CYCLES = 11;
    localparam int IDLE_PCT     = 36;
    localparam int STALL_LIMIT  = 4000;
    localparam int PHASES       = 9;
    localparam int PHASE_ITEMS  = 28;
    localparam int TAIL_CYCLES  = 40;

    localparam logic [PADDR_W-1:0] ADDR_RADIX  = PADDR_W'(4 * REG_RADIX);
    localparam logic [PADDR_W-1:0] ADDR_UNUSED = PADDR_W'(4 * (REG_RADIX + 1));

    typedef struct {
        logic [CHAR_W-1:0] code;
        logic              last;
    } t_digit;

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic [VALUE_BITS-1:0] i_value = '0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic [CHAR_W-1:0]     o_digit_char;
    logic                  o_last;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [PADDR_W-1:0]    paddr   = '0;
    logic [PDATA_W-1:0]    pwdata  = '0;
    logic [PDATA_W-1:0]    prdata;
    logic                  pready;

    logic [VALUE_BITS-1:0] values_pending [$];
    t_digit                digits_due [$];
    t_digit                digit_want;
    logic [RADIX_W-1:0]    radix_model = RADIX_RESET;
    logic                  steady = 1'b0;
    int unsigned           values_queued   = 0;
    int unsigned           values_accepted = 0;
    int unsigned           digits_checked  = 0;
    int unsigned           radix_writes    = 0;
    int unsigned           mismatches      = 0;
    int unsigned           quiet_cycles    = 0;

    unsigned_to_radix_digits_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_digit_char (o_digit_char),
        .o_last       (o_last),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    function automatic void predict_digits(input logic [VALUE_BITS-1:0] value,
                                           input logic [RADIX_W-1:0] base);
        logic [DIGIT_W-1:0]    rems [$];
        logic [VALUE_BITS-1:0] quot;
        logic [DIGIT_W-1:0]    d;
        t_digit                dig;
        quot = value;
        do begin
            rems.push_back(DIGIT_W'(quot % base));
            quot = quot / base;
        end while (quot != 0 && rems.size() < MAX_DIGITS);
        while (rems.size() > 0) begin
            d = rems.pop_back();
            dig.code = (d < 10) ? CHAR_W'(8'h30 + d) : CHAR_W'(8'h41 + d - 10);
            dig.last = (rems.size() == 0);
            digits_due.push_back(dig);
        end
    endfunction

    function automatic logic [VALUE_BITS-1:0] pick_value(input int unsigned base);
        logic [63:0] p;
        int unsigned sel;
        sel = $urandom_range(0, 9);
        p = 64'd1;
        case (sel)
            0, 1, 2, 3: return $urandom;
            4, 5:       return $urandom >> $urandom_range(0, 31);
            6:          return $urandom_range(0, base * base);
            7, 8: begin
                repeat ($urandom_range(1, 32)) begin
                    if (p * base <= 64'hFFFF_FFFF) p = p * base;
                end
                return (sel == 7) ? VALUE_BITS'(p - 1) : VALUE_BITS'(p);
            end
            default:    return 32'hFFFF_FFFF - $urandom_range(0, 255);
        endcase
    endfunction

    function automatic void queue_value(input logic [VALUE_BITS-1:0] value);
        values_pending.push_back(value);
        values_queued++;
    endfunction

    task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] addr,
                              input logic [PDATA_W-1:0] wdata,
                              output logic [PDATA_W-1:0] rdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_radix();
        logic [PDATA_W-1:0] rd;
        apb_access(1'b0, ADDR_RADIX, $urandom, rd);
        if (rd !== PDATA_W'(radix_model))
            report_mismatch($sformatf("radix read %0d, want %0d", rd, radix_model));
    endtask

    task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        logic [PDATA_W-1:0] rd;
        apb_access(1'b1, addr, data, rd);
        radix_writes++;
        if (addr == ADDR_RADIX && data[RADIX_W-1:0] >= RADIX_MIN
                && data[RADIX_W-1:0] <= RADIX_MAX)
            radix_model = data[RADIX_W-1:0];
        check_radix();
    endtask

    task automatic drain();
        do @(posedge i_clk);
        while (values_accepted != values_queued || digits_due.size() != 0);
    endtask

    // driver: hold the value until transfer, then take the next one or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                predict_digits(i_value, radix_model);
                values_accepted++;
            end
            if (!i_valid || o_ready) begin
                if (values_pending.size() != 0
                        && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    i_value <= values_pending.pop_front();
                    i_valid <= 1'b1;
                end else begin
                    i_value <= $urandom;
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each digit transfer with the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (digits_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected digit %h last %b",
                                              o_digit_char, o_last));
                end else begin
                    digit_want = digits_due.pop_front();
                    if (o_digit_char !== digit_want.code)
                        report_mismatch($sformatf("digit %h, want %h",
                                                  o_digit_char, digit_want.code));
                    if (o_last !== digit_want.last)
                        report_mismatch($sformatf("last %b, want %b",
                                                  o_last, digit_want.last));
                    digits_checked++;
                end
            end
            i_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    initial begin
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready) || (psel && penable))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        logic [PDATA_W-1:0] word;
        int unsigned        base;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        check_radix();

        queue_value(32'd0);
        queue_value(32'd1);
        queue_value(32'd9);
        queue_value(32'd10);
        queue_value(32'd999_999_999);
        queue_value(32'd1_000_000_000);
        queue_value(32'hFFFF_FFFF);
        drain();

        write_reg(ADDR_RADIX, PDATA_W'(RADIX_MAX));
        queue_value(32'd0);
        queue_value(32'd15);
        queue_value(32'd16);
        queue_value(32'h0123_ABCD);
        queue_value(32'hFEDC_BA98);
        queue_value(32'hFFFF_FFFF);
        drain();

        write_reg(ADDR_RADIX, PDATA_W'(RADIX_MIN));
        queue_value(32'd0);
        queue_value(32'd1);
        queue_value(32'h8000_0000);
        queue_value(32'hAAAA_AAAA);
        queue_value(32'hFFFF_FFFF);
        drain();

        // out-of-range radix and the unmapped address leave the setting alone; the last write sets radix 3
        write_reg(ADDR_RADIX, 32'd0);
        write_reg(ADDR_RADIX, 32'd1);
        write_reg(ADDR_RADIX, 32'd17);
        write_reg(ADDR_RADIX, 32'd31);
        write_reg(ADDR_UNUSED, 32'd5);
        write_reg(ADDR_RADIX, 32'hFFFF_FFE3);
        queue_value(32'd0);
        queue_value(32'hFFFF_FFFF);
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            base = (ph == 0) ? RADIX_MIN : (ph == 1) ? RADIX_MAX : $urandom_range(2, 16);
            if ($urandom_range(0, 1)) begin
                word = $urandom;
                word[RADIX_W-1:0] = RADIX_W'($urandom_range(17, 31));
                write_reg(ADDR_RADIX, word);
            end
            word = $urandom;
            word[RADIX_W-1:0] = RADIX_W'(base);
            write_reg(ADDR_RADIX, word);
            steady = (ph == 4);
            for (int k = 0; k < PHASE_ITEMS; k++)
                queue_value(pick_value(base));
            drain();
            steady = 1'b0;
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (digits_due.size() != 0)
            report_mismatch($sformatf("%0d digits never arrived", digits_due.size()));
        $display("converted %0d values into %0d checked digits", values_accepted,
                 digits_checked);
        $display("%0d register writes, radix 2 to 16 with rejected values", radix_writes);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
